FILE: rtl/core/tcf_pkg.sv
// Shared types, constants and the arctangent table of the tilt filter.
`timescale 1ns / 1ps
package tcf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_PITCH_BIAS   = 2'd0;
  localparam logic [1:0] REG_PITCH_WEIGHT = 2'd1;
  localparam logic [1:0] REG_ROLL_WEIGHT  = 2'd2;

  localparam logic signed [9:0] PITCH_BIAS_RESET   = 10'sd2;
  localparam logic [15:0]       PITCH_WEIGHT_RESET = 16'd65470;
  localparam logic [15:0]       ROLL_WEIGHT_RESET  = 16'd65208;

  localparam logic [19:0] US_PER_SECOND = 20'd1000000;
  // One million is 64 * 15625. This is 2^66 / 15625 rounded up, exact for
  // every quotient of a dividend below 2^52.
  localparam logic [52:0] DIV_RECIP     = 53'd4722366482869646;
  localparam logic [29:0] INV_GAIN      = 30'd652032874;
  localparam logic [26:0] DEG_TO_RAD    = 27'd74961321;

  // CORDIC datapath widths.
  localparam int CW = 36;
  localparam int ZW = 35;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] ATAN_TAB [11] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635, 32'd268086748,
    32'd134174063, 32'd67103403, 32'd33553749, 32'd16777131, 32'd8388597,
    32'd4194303
  };

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [16:0] rate_p;
    logic signed [16:0] rate_r;
    logic [19:0]        dt;
    logic               zero_p;
    logic               zero_r;
  } tcf_item_t;

  typedef struct packed {
    logic signed [15:0] num;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               zero;
    logic signed [16:0] rate;
    logic [19:0]        dt;
    logic               negate;
    logic [15:0]        weight;
    logic signed [31:0] est;
  } tcf_op_t;

  // Arctangent of 2^-i in Q32; beyond the table it equals 2^(32-i).
  function automatic logic [31:0] atan_q32(input logic [4:0] i);
    logic [31:0] v;
    if (i < 5'd11) begin
      v = ATAN_TAB[i[3:0]];
    end else begin
      v = 32'h1 << (6'd32 - {1'b0, i});
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/tcf_front.sv
// Front end: clamps the interval, adds the pitch bias and flags zero vectors.
`timescale 1ns / 1ps
module tcf_front import tcf_pkg::*; (
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic [19:0]        elapsed_us,
  input  logic signed [9:0]  pitch_bias,
  output tcf_item_t          item
);

  always_comb begin
    item.ax     = accel_x;
    item.ay     = accel_y;
    item.az     = accel_z;
    item.rate_p = 17'(rate_y) + 17'(pitch_bias);
    item.rate_r = 17'(rate_x);
    item.dt     = (elapsed_us > US_PER_SECOND) ? US_PER_SECOND : elapsed_us;
    item.zero_p = (accel_y == 16'sd0) && (accel_z == 16'sd0);
    item.zero_r = (accel_x == 16'sd0) && (accel_z == 16'sd0);
  end

endmodule

FILE: rtl/core/tcf_queue.sv
// Two-entry queue between the front end and the filter engines.
`timescale 1ns / 1ps
module tcf_queue import tcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tcf_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output tcf_item_t item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  tcf_item_t      mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/tcf_axis.sv
// One axis engine: CORDIC tilt angle, gyro increment and weighted blend.
`timescale 1ns / 1ps
module tcf_axis import tcf_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               ack,
  input  tcf_op_t            op,
  output logic               done,
  output logic signed [31:0] result
);

  localparam int SW      = $clog2(CORDIC_STEPS);
  localparam int SHIFT_S = 32 - ANGLE_FRAC_BITS;
  localparam logic signed [ZW-1:0] ZROUND   = ZW'(1) << (31 - ANGLE_FRAC_BITS);
  localparam logic [63:0]          HALF_DEN = 64'(500000) << SHIFT_S;

  typedef enum logic [6:0] {
    C_IDLE = 7'b0000001,
    C_V1   = 7'b0000010,
    C_MUL  = 7'b0000100,
    C_SUM  = 7'b0001000,
    C_V2   = 7'b0010000,
    C_RND  = 7'b0100000,
    C_DONE = 7'b1000000
  } cstate_t;

  typedef enum logic [6:0] {
    G_IDLE = 7'b0000001,
    G_MUL  = 7'b0000010,
    G_PART = 7'b0000100,
    G_SUM  = 7'b0001000,
    G_DIV  = 7'b0010000,
    G_QUO  = 7'b0100000,
    G_DONE = 7'b1000000
  } gstate_t;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_WAIT = 5'b00010,
    B_MUL  = 5'b00100,
    B_FIN  = 5'b01000,
    B_DONE = 5'b10000
  } bstate_t;

  cstate_t cstate;
  gstate_t gstate;
  bstate_t bstate;
  tcf_op_t op_q;

  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz, acc;
  logic [SW-1:0]        step;
  logic [46:0]          m_lo, m_hi;

  logic signed [37:0]   gp;
  logic                 gneg;
  logic [44:0]          g_lo, g_hi;
  logic [57:0]          dividend;
  logic [51:0]          pp_ll, pp_hl;
  logic [52:0]          pp_lh, pp_hh;
  logic [39:0]          quo;

  logic signed [58:0]   pg;
  logic signed [52:0]   pa;

  // CORDIC micro-rotation.
  logic signed [CW-1:0] dx, dy, cx_n, cy_n;
  logic signed [ZW-1:0] zstep, cz_n;
  logic [31:0]          at;
  logic                 last_step;
  logic [16:0]          a_abs, b_abs;
  logic signed [16:0]   a_ext, b_ext;

  always_comb begin
    dx        = cy >>> step;
    dy        = cx >>> step;
    at        = atan_q32(5'(step));
    zstep     = $signed({{(ZW-32){1'b0}}, at});
    last_step = (step == SW'(CORDIC_STEPS - 1));
    if (!cy[CW-1]) begin
      cx_n = cx + dx;
      cy_n = cy - dy;
      cz_n = cz + zstep;
    end else begin
      cx_n = cx - dx;
      cy_n = cy + dy;
      cz_n = cz - zstep;
    end
    a_ext = 17'(op.a);
    b_ext = 17'(op.b);
    a_abs = (a_ext < 0) ? 17'(-a_ext) : 17'(a_ext);
    b_abs = (b_ext < 0) ? 17'(-b_ext) : 17'(b_ext);
  end

  logic [63:0] mtot;
  logic [37:0] gmag;
  logic [63:0] gsum;
  logic [105:0] qsum;
  logic signed [40:0] delta;
  logic signed [41:0] esum;
  logic signed [63:0] bsum;
  logic signed [47:0] bround;

  always_comb begin
    mtot = ({17'b0, m_hi} << 17) + {17'b0, m_lo} + 64'(1 << 29);
    gmag = gp[37] ? 38'(-gp) : 38'(gp);
    gsum = ({19'b0, g_hi} << 18) + {19'b0, g_lo} + HALF_DEN;
    // Division by one million: drop the factor 64, then multiply by the
    // scaled reciprocal of 15625 from four registered partial products.
    qsum = ({53'b0, pp_hh} << 52) + ({53'b0, pp_lh} << 26)
         + ({54'b0, pp_hl} << 26) + {54'b0, pp_ll};
    delta = (gneg ^ op_q.negate) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    esum  = 42'(op_q.est) + 42'(delta);
    bsum  = 64'(pg) + 64'(pa);
    bround = 48'((bsum + 64'sd32768) >>> 16);
  end

  assign done = (bstate == B_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= C_IDLE;
      gstate <= G_IDLE;
      bstate <= B_IDLE;
    end else begin
      case (cstate)
        C_IDLE: begin
          if (start) begin
            if (op.zero) begin
              acc    <= '0;
              cstate <= C_DONE;
            end else begin
              cx     <= $signed(CW'({a_abs, 16'h0000}));
              cy     <= $signed(CW'({b_abs, 16'h0000}));
              cz     <= '0;
              step   <= '0;
              cstate <= C_V1;
            end
          end
        end
        C_V1, C_V2: begin
          cx   <= cx_n;
          cy   <= cy_n;
          cz   <= cz_n;
          step <= step + 1'b1;
          if (last_step) begin
            cstate <= (cstate == C_V1) ? C_MUL : C_RND;
          end
        end
        C_MUL: begin
          m_lo   <= cx[16:0] * INV_GAIN;
          m_hi   <= cx[33:17] * INV_GAIN;
          cstate <= C_SUM;
        end
        C_SUM: begin
          cx     <= $signed(CW'(mtot[63:30]));
          cy     <= CW'($signed({op_q.num, 16'h0000}));
          cz     <= '0;
          step   <= '0;
          cstate <= C_V2;
        end
        C_RND: begin
          acc    <= (cz + ZROUND) >>> SHIFT_S;
          cstate <= C_DONE;
        end
        C_DONE: begin
          cstate <= C_DONE;
        end
        default: cstate <= C_IDLE;
      endcase

      case (gstate)
        G_IDLE: begin
          if (start) begin
            gstate <= G_MUL;
          end
        end
        G_MUL: begin
          gp     <= $signed(op_q.rate) * $signed({1'b0, op_q.dt});
          gstate <= G_PART;
        end
        G_PART: begin
          g_lo   <= gmag[17:0] * DEG_TO_RAD;
          g_hi   <= gmag[35:18] * DEG_TO_RAD;
          gneg   <= gp[37];
          gstate <= G_SUM;
        end
        G_SUM: begin
          dividend <= 58'(gsum >> SHIFT_S);
          gstate   <= G_DIV;
        end
        G_DIV: begin
          pp_ll  <= dividend[31:6] * DIV_RECIP[25:0];
          pp_lh  <= dividend[31:6] * DIV_RECIP[52:26];
          pp_hl  <= dividend[57:32] * DIV_RECIP[25:0];
          pp_hh  <= dividend[57:32] * DIV_RECIP[52:26];
          gstate <= G_QUO;
        end
        G_QUO: begin
          quo    <= qsum[105:66];
          gstate <= G_DONE;
        end
        G_DONE: begin
          gstate <= G_DONE;
        end
        default: gstate <= G_IDLE;
      endcase

      case (bstate)
        B_IDLE: begin
          if (start) begin
            op_q   <= op;
            bstate <= B_WAIT;
          end
        end
        B_WAIT: begin
          if (cstate == C_DONE && gstate == G_DONE) begin
            bstate <= B_MUL;
          end
        end
        B_MUL: begin
          pg     <= esum * $signed({1'b0, op_q.weight});
          pa     <= acc * $signed(18'h10000 - {2'b00, op_q.weight});
          bstate <= B_FIN;
        end
        B_FIN: begin
          if (bround > 48'sd2147483647) begin
            result <= 32'sh7fffffff;
          end else if (bround < -48'sd2147483648) begin
            result <= 32'sh80000000;
          end else begin
            result <= bround[31:0];
          end
          bstate <= B_DONE;
        end
        B_DONE: begin
          if (ack) begin
            bstate <= B_IDLE;
            cstate <= C_IDLE;
            gstate <= G_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/tcf_back.sv
// Back end: runs the pitch and roll engines, keeps the estimates, holds the result.
`timescale 1ns / 1ps
module tcf_back import tcf_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  tcf_item_t          q_item,
  output logic               q_pop,
  input  logic [15:0]        pitch_weight,
  input  logic [15:0]        roll_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pitch_angle,
  output logic signed [31:0] roll_angle
);

  logic               busy;
  logic               start, finish;
  logic               p_done, r_done;
  logic signed [31:0] p_res, r_res;
  logic signed [31:0] pitch_est, roll_est;
  tcf_op_t            p_op, r_op;

  assign start  = q_valid && !busy;
  assign q_pop  = start;
  assign finish = busy && p_done && r_done && (!out_valid || out_ready);

  always_comb begin
    p_op.num    = q_item.ax;
    p_op.a      = q_item.ay;
    p_op.b      = q_item.az;
    p_op.zero   = q_item.zero_p;
    p_op.rate   = q_item.rate_p;
    p_op.dt     = q_item.dt;
    p_op.negate = 1'b1;
    p_op.weight = pitch_weight;
    p_op.est    = pitch_est;
    r_op.num    = q_item.ay;
    r_op.a      = q_item.ax;
    r_op.b      = q_item.az;
    r_op.zero   = q_item.zero_r;
    r_op.rate   = q_item.rate_r;
    r_op.dt     = q_item.dt;
    r_op.negate = 1'b0;
    r_op.weight = roll_weight;
    r_op.est    = roll_est;
  end

  tcf_axis #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
    .clk(clk), .rst(rst), .start(start), .ack(finish), .op(p_op),
    .done(p_done), .result(p_res)
  );

  tcf_axis #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk(clk), .rst(rst), .start(start), .ack(finish), .op(r_op),
    .done(r_done), .result(r_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pitch_est <= '0;
      roll_est  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end
      if (finish) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        pitch_est <= p_res;
        roll_est  <= r_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      pitch_angle <= p_res;
      roll_angle  <= r_res;
    end
  end

endmodule

FILE: rtl/core/tilt_complementary_filter.sv
// Top level of the tilt complementary filter: configuration, front end, queue, back end.
//
//   Channel  Direction  Handshake               Payload
//   in       request    in_valid / in_ready     accel_x/y/z, rate_x, rate_y, elapsed_us
//   out      result     out_valid / out_ready   pitch_angle, roll_angle
//   cfg      write      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// In the back end the two CORDIC vectoring passes of each axis engine set the time that a
// request takes, and the gyro multiply and divide run beside them. Pitch and roll run in
// parallel engines. Reset is synchronous and active high; it zeroes both estimates and
// loads the register defaults. A two-entry queue lets the front end take requests while
// the back end is busy, and the output register lets the next request start while a
// result waits.
`timescale 1ns / 1ps
module tilt_complementary_filter import tcf_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic [19:0]        elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pitch_angle,
  output logic signed [31:0] roll_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // Configuration registers. Writes must arrive only while the block is idle, which the block
  // itself does not enforce; the front end and the engines read them directly.
  logic signed [9:0] pitch_bias;
  logic [15:0]       pitch_weight;
  logic [15:0]       roll_weight;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_bias   <= PITCH_BIAS_RESET;
      pitch_weight <= PITCH_WEIGHT_RESET;
      roll_weight  <= ROLL_WEIGHT_RESET;
    end else if (cfg_valid) begin
      // An index outside the register list is ignored.
      case (cfg_index)
        REG_PITCH_BIAS:   pitch_bias   <= cfg_data[9:0];
        REG_PITCH_WEIGHT: pitch_weight <= cfg_data;
        REG_ROLL_WEIGHT:  roll_weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  tcf_item_t front_item, q_item;
  logic      q_full, q_valid, q_pop, push;

  // A request is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  tcf_front u_front (
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .rate_x(rate_x), .rate_y(rate_y), .elapsed_us(elapsed_us),
    .pitch_bias(pitch_bias), .item(front_item)
  );

  tcf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(front_item), .full(q_full),
    .pop(q_pop), .valid(q_valid), .item(q_item)
  );

  tcf_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .pitch_weight(pitch_weight), .roll_weight(roll_weight),
    .out_valid(out_valid), .out_ready(out_ready),
    .pitch_angle(pitch_angle), .roll_angle(roll_angle)
  );

endmodule

FILE: rtl/core/tcf_checker.sv
// Port-level checker for the tilt filter and its bind to the top level.
`timescale 1ns / 1ps
module tcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pitch_angle,
  input logic [31:0] roll_angle
);

  // Requests taken but not yet delivered: queue, engines and output register.
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pitch_angle) && $stable(roll_angle))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a pending request");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending == 3'd4 |-> !in_ready)
    else $error("request taken beyond capacity");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result visible right after reset");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .pitch_angle(pitch_angle), .roll_angle(roll_angle)
);
